// File: rtl/blte_pkg.sv
package blte_pkg;

   // list geometry
   localparam int LIST_CAP = 32;
   localparam int IDX_W    = $clog2(LIST_CAP);
   localparam int CNT_W    = $clog2(LIST_CAP + 1);

   // command codes
   localparam logic [2:0] ACT_APPEND  = 3'd0;
   localparam logic [2:0] ACT_PREPEND = 3'd1;
   localparam logic [2:0] ACT_SORTED  = 3'd2;
   localparam logic [2:0] ACT_DELETE  = 3'd3;
   localparam logic [2:0] ACT_REPLACE = 3'd4;
   localparam logic [2:0] ACT_READ    = 3'd5;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_EMPTY     = 2'd3;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] value;
      logic [7:0] new_value;
   } req_type;

   typedef struct packed {
      logic [7:0] item;
      logic [1:0] status;
      logic       last;
   } rsp_type;

endpackage

// File: rtl/byte_list_table_engine_top.sv
// channel   direction  payload    handshake
// req_      in         req_type   req_valid / req_stall
// rsp_      out        rsp_type   rsp_valid / rsp_stall
//
// Each command walks the stored list through one RAM read port, one entry
// per cycle unless a stalled result holds a read out. Insert, delete and
// replace walk the whole list (appends walk the list too) and then close in
// S_FIN; a read out walks the list and returns to idle; a full insert, an empty
// read out and an undefined action go straight to S_FIN. The list RAM read latency sets the walk.
// Synchronous reset empties the list; RAM contents are not cleared.
// A stalled result holds the walk of a read out; req_stall is high while busy.
module byte_list_table_engine_top
   import blte_pkg::*;
   (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
   );

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rd_vld_ff, rd_vld_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       op_ff, op_in;
   logic [7:0]       value_ff, value_in;
   logic [7:0]       newv_ff, newv_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0] proc_idx_ff, proc_idx_in;
   logic [CNT_W-1:0] wr_idx_ff, wr_idx_in;
   logic [7:0]       carry_ff, carry_in;
   logic             ins_ff, ins_in;
   logic             found_ff, found_in;
   logic [1:0]       fin_stat_ff, fin_stat_in;
   rsp_type          rsp_ff, rsp_in;

   logic             out_free, proc, issue_rd, scan_end;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [7:0]       wr_data;
   logic [7:0]       rd_data;
   logic             is_insert;

   blte_ram #(.DEPTH(LIST_CAP), .WIDTH(8), .AW(IDX_W)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue_rd),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign is_insert = (op_ff inside {ACT_APPEND, ACT_PREPEND, ACT_SORTED});

   // walk control: process the entry in the read register, fetch the next
   always_comb begin
      proc     = (state_ff == S_SCAN) && rd_vld_ff && ((op_ff != ACT_READ) || out_free);
      issue_rd = (state_ff == S_SCAN) && (rd_idx_ff < count_ff) && (!rd_vld_ff || proc);
      scan_end = (state_ff == S_SCAN) && (rd_idx_ff == count_ff) && !rd_vld_ff;
   end

   // command sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rd_vld_in    = rd_vld_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      op_in        = op_ff;
      value_in     = value_ff;
      newv_in      = newv_ff;
      rd_idx_in    = rd_idx_ff;
      proc_idx_in  = proc_idx_ff;
      wr_idx_in    = wr_idx_ff;
      carry_in     = carry_ff;
      ins_in       = ins_ff;
      found_in     = found_ff;
      fin_stat_in  = fin_stat_ff;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = proc_idx_ff;
      wr_data      = carry_ff;

      // read pipeline bookkeeping
      if (issue_rd) begin
         rd_vld_in   = 1'b1;
         proc_idx_in = rd_idx_ff[IDX_W-1:0];
         rd_idx_in   = rd_idx_ff + CNT_W'(1);
      end else if (proc) begin
         rd_vld_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in       = req_data.action;
               value_in    = req_data.value;
               newv_in     = req_data.new_value;
               rd_idx_in   = '0;
               rd_vld_in   = 1'b0;
               wr_idx_in   = '0;
               carry_in    = req_data.value;
               ins_in      = (req_data.action == ACT_PREPEND);
               found_in    = 1'b0;
               fin_stat_in = ST_OK;
               if (req_data.action inside {ACT_APPEND, ACT_PREPEND, ACT_SORTED}) begin
                  if (count_ff == CNT_W'(LIST_CAP)) begin
                     fin_stat_in = ST_FULL;
                     state_in    = S_FIN;
                  end else begin
                     state_in = S_SCAN;
                  end
               end else if (req_data.action == ACT_READ) begin
                  if (count_ff == '0) begin
                     fin_stat_in = ST_EMPTY;
                     state_in    = S_FIN;
                  end else begin
                     state_in = S_SCAN;
                  end
               end else if (req_data.action inside {ACT_DELETE, ACT_REPLACE}) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_FIN;
               end
            end
         end

         S_SCAN: begin
            // per-entry work on the entry just read
            if (proc) begin
               case (op_ff)
                  ACT_APPEND, ACT_PREPEND, ACT_SORTED: begin
                     if (ins_ff) begin
                        wr_en    = 1'b1;
                        wr_data  = carry_ff;
                        carry_in = rd_data;
                     end else if ((op_ff == ACT_SORTED) && (rd_data > value_ff)) begin
                        wr_en    = 1'b1;
                        wr_data  = value_ff;
                        carry_in = rd_data;
                        ins_in   = 1'b1;
                     end
                  end
                  ACT_DELETE: begin
                     if (rd_data == value_ff) begin
                        found_in = 1'b1;
                     end else begin
                        wr_en     = 1'b1;
                        wr_addr   = wr_idx_ff[IDX_W-1:0];
                        wr_data   = rd_data;
                        wr_idx_in = wr_idx_ff + CNT_W'(1);
                     end
                  end
                  ACT_REPLACE: begin
                     if (rd_data == value_ff) begin
                        wr_en    = 1'b1;
                        wr_data  = newv_ff;
                        found_in = 1'b1;
                     end
                  end
                  ACT_READ: begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.item   = rd_data;
                     rsp_in.status = ST_OK;
                     rsp_in.last   = ((CNT_W'(proc_idx_ff) + CNT_W'(1)) == count_ff);
                  end
                  default: begin
                  end
               endcase
            end
            if (scan_end) begin
               state_in = (op_ff == ACT_READ) ? S_IDLE : S_FIN;
            end
         end

         S_FIN: begin
            // closing write and the single result transaction
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.item  = 8'd0;
               rsp_in.last  = 1'b1;
               if (op_ff inside {ACT_DELETE, ACT_REPLACE}) begin
                  rsp_in.status = found_ff ? ST_OK : ST_NOT_FOUND;
               end else begin
                  rsp_in.status = fin_stat_ff;
               end
               if (is_insert && (fin_stat_ff == ST_OK)) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[IDX_W-1:0];
                  wr_data  = ins_ff ? carry_ff : value_ff;
                  count_in = count_ff + CNT_W'(1);
               end
               if (op_ff == ACT_DELETE) begin
                  count_in = wr_idx_ff;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and walk registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      value_ff    <= value_in;
      newv_ff     <= newv_in;
      rd_idx_ff   <= rd_idx_in;
      proc_idx_ff <= proc_idx_in;
      wr_idx_ff   <= wr_idx_in;
      carry_ff    <= carry_in;
      ins_ff      <= ins_in;
      found_ff    <= found_in;
      fin_stat_ff <= fin_stat_in;
      rsp_ff      <= rsp_in;
   end

endmodule

// File: rtl/blte_ram.sv
module blte_ram
   #(parameter int DEPTH = 32,
     parameter int WIDTH = 8,
     parameter int AW    = $clog2(DEPTH))
   (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
   );

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // one read port, registered, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
